// ===== rtl/core/pote_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PTP offset engine package
// Shared types, widths, codes and the timestamp conversion function.
// ----------------------------------------------------------------------------
package pote_pkg;

  localparam int unsigned TS_W     = 48;
  localparam int unsigned ALU_W    = 52;
  localparam int unsigned MAG_W    = 49;
  localparam int unsigned ACC_W    = 50;
  localparam int unsigned FREQ_W   = 28;
  localparam int unsigned RC_W     = 7;
  localparam int unsigned PER_W    = 11;
  localparam int unsigned DIV_W    = 50;
  localparam int unsigned DIV_CW   = 6;
  localparam int unsigned HI_W     = 42;
  localparam int unsigned RCP_W    = 44;
  localparam int unsigned PROD_W   = ACC_W + RCP_W;
  localparam int unsigned MUL_AW   = 25;
  localparam int unsigned MUL_BW   = 22;
  localparam int unsigned PP_W     = MUL_AW + MUL_BW;

  // Reciprocal of 125 scaled by 2^50, exact for dividends below 2^50.
  localparam logic [RCP_W-1:0]  RCP_125      = 44'd9007199254741;
  localparam logic [2:0]        MIX_STEPS    = 3'd4;
  localparam logic [16:0]       FREQ_SCALE   = 17'd125000;
  localparam logic [ACC_W-1:0]  ACC_MAX      = '1;
  localparam logic [6:0]        LAST_STEP    = 7'd124;

  localparam logic OP_SYNC  = 1'b0;
  localparam logic OP_DELAY = 1'b1;

  localparam logic REG_SYNC_PERIOD = 1'b0;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_MS1,
    ST_MS2,
    ST_SM1,
    ST_SM2,
    ST_DIFF,
    ST_ABS,
    ST_MIX,
    ST_MIXW,
    ST_G1,
    ST_G2,
    ST_FREQ,
    ST_FREQW,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // A mixed-radix timestamp as a linear count of 8 ns steps: hi*125 + lo.
  function automatic logic [ALU_W-1:0] to_linear(input logic [TS_W-1:0] v);
    logic [ALU_W-1:0] hi;
    logic [ALU_W-1:0] lo;
    hi = ALU_W'(v[TS_W-1:7]);
    lo = ALU_W'(v[6:0]);
    return (hi << 7) - (hi << 1) - hi + lo;
  endfunction

endpackage

// ===== rtl/core/ptp_offset_table_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PTP offset table engine
// Per-node two-step offset computation with guide-frequency tracking.
// ----------------------------------------------------------------------------
// A Sync transfer leaves busy low.
// A delay request transfer keeps busy high, both while its node warms up and once
// tracking runs, including any wait on the frequency divider; the result strobes in
// the next cycle, which can also take a new transfer. The receiver cannot stall.
// After reset a clearing pass zeroes every entry of the tracking table with busy
// high; configuration writes are taken throughout.
module ptp_offset_table_engine #(
  parameter int unsigned NODES         = 1024,
  parameter int unsigned WARMUP_ROUNDS = 100
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           operation_i,
  input  logic [9:0]                     node_i,
  input  logic [pote_pkg::TS_W-1:0]      ts_first_i,
  input  logic [pote_pkg::TS_W-1:0]      ts_second_i,
  input  logic [pote_pkg::TS_W-1:0]      correction_i,
  output logic                           result_valid_o,
  output logic [pote_pkg::MAG_W-1:0]     offset_magnitude_o,
  output logic                           offset_sign_o,
  output logic                           guide_enable_o,
  output logic                           guide_sign_o,
  output logic [pote_pkg::FREQ_W-1:0]    guide_frequency_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int unsigned AW   = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned SY_W = 3 * pote_pkg::TS_W;
  localparam int unsigned GD_W = pote_pkg::RC_W + pote_pkg::ACC_W + 1;
  localparam logic [pote_pkg::RC_W-1:0] WARM = pote_pkg::RC_W'(WARMUP_ROUNDS);

  pote_pkg::state_e state_q, state_d;

  logic [SY_W-1:0] sync_mem [NODES];
  logic [GD_W-1:0] guide_mem [NODES];

  logic [SY_W-1:0]               sy_q;
  logic [GD_W-1:0]               gd_q;
  logic [AW-1:0]                 addr_i;
  logic [AW-1:0]                 node_q;
  logic [AW-1:0]                 clr_q, clr_d;
  logic [pote_pkg::TS_W-1:0]     ta_q, tb_q, corr_q;
  logic [pote_pkg::ALU_W-1:0]    w_q, w_d, ms_q, ms_d;
  logic                          flag_q, flag_d, gsign_q, gsign_d;
  logic [pote_pkg::ACC_W-1:0]    half_q, half_d, acc_q, acc_d;
  logic [pote_pkg::MAG_W-1:0]    mag_q, mag_d;
  logic [pote_pkg::FREQ_W-1:0]   num_q, num_d, freq_q, freq_d;
  logic [pote_pkg::PROD_W-1:0]   prod_q, prod_d;
  logic [2:0]                    step_q, step_d;
  logic [pote_pkg::MUL_AW-1:0]   mul_a;
  logic [pote_pkg::MUL_BW-1:0]   mul_b;
  logic [pote_pkg::PP_W-1:0]     mul_p;
  logic [pote_pkg::PROD_W-1:0]   pp_sh;
  logic [pote_pkg::RCP_W-1:0]    quo;
  logic [6:0]                    rem;
  logic [pote_pkg::PER_W-1:0]    period_q;
  logic                          node_ok, accept, cfg_wr, tracking;
  logic                          gwr;
  logic [GD_W-1:0]               gwdata;
  logic [pote_pkg::RC_W-1:0]     rc, rc_new;
  logic [pote_pkg::ACC_W-1:0]    acc_mem;
  logic                          sign_mem;
  logic                          res_valid_q;
  logic [pote_pkg::MAG_W-1:0]    res_mag_q;
  logic                          res_sign_q, res_gen_q, res_gsign_q;
  logic [pote_pkg::FREQ_W-1:0]   res_freq_q;
  logic [pote_pkg::ALU_W-1:0]    alu_res;
  pote_pkg::alu_req_t            alu_req;
  pote_pkg::div_req_t            div_req;
  pote_pkg::div_rsp_t            div_rsp;

  assign addr_i   = AW'(node_i);
  assign node_ok  = 32'(node_i) < NODES;
  assign accept   = start && !busy;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign busy     = (state_q != pote_pkg::ST_IDLE);
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == pote_pkg::REG_SYNC_PERIOD) ? 32'(period_q) : '0;
  assign rc       = gd_q[GD_W-1 -: pote_pkg::RC_W];
  assign acc_mem  = gd_q[pote_pkg::ACC_W:1];
  assign sign_mem = gd_q[0];
  assign tracking = rc >= WARM;
  assign rc_new   = (rc <= WARM) ? rc + 1'b1 : rc;

  // The quotient by 125 is a reciprocal product built from four partial products.
  assign mul_a = step_q[1] ? half_q[pote_pkg::ACC_W-1 -: pote_pkg::MUL_AW]
                           : half_q[pote_pkg::MUL_AW-1:0];
  assign mul_b = step_q[0] ? pote_pkg::RCP_125[pote_pkg::RCP_W-1 -: pote_pkg::MUL_BW]
                           : pote_pkg::RCP_125[pote_pkg::MUL_BW-1:0];
  assign mul_p = pote_pkg::PP_W'(mul_a) * pote_pkg::PP_W'(mul_b);
  assign quo   = prod_q[pote_pkg::PROD_W-1 -: pote_pkg::RCP_W];
  assign rem   = half_q[6:0] + quo[6:0] + {quo[5:0], 1'b0};

  always_comb begin
    case (step_q[1:0])
      2'd0:    pp_sh = pote_pkg::PROD_W'(mul_p);
      2'd1:    pp_sh = pote_pkg::PROD_W'(mul_p) << pote_pkg::MUL_BW;
      2'd2:    pp_sh = pote_pkg::PROD_W'(mul_p) << pote_pkg::MUL_AW;
      default: pp_sh = pote_pkg::PROD_W'(mul_p) << pote_pkg::PP_W;
    endcase
  end

  pote_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  pote_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    w_d     = w_q;
    ms_d    = ms_q;
    flag_d  = flag_q;
    gsign_d = gsign_q;
    half_d  = half_q;
    acc_d   = acc_q;
    mag_d   = mag_q;
    num_d   = num_q;
    freq_d  = freq_q;
    prod_d  = prod_q;
    step_d  = step_q;
    alu_req = '{a: '0, b: '0, sub: 1'b0};
    div_req = '{start: 1'b0, dividend: '0, divisor: '0};
    gwr     = 1'b0;
    gwdata  = '0;
    unique case (state_q)
      pote_pkg::ST_CLR: begin
        gwr   = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(NODES - 1)) begin
          state_d = pote_pkg::ST_IDLE;
        end
      end
      pote_pkg::ST_IDLE: begin
        if (accept && node_ok && operation_i == pote_pkg::OP_DELAY) begin
          state_d = pote_pkg::ST_MS1;
        end
      end
      pote_pkg::ST_MS1: begin
        alu_req = '{a: pote_pkg::to_linear(sy_q[SY_W-1 -: pote_pkg::TS_W]),
                    b: pote_pkg::ALU_W'(sy_q[pote_pkg::TS_W-1:0]), sub: 1'b0};
        w_d     = alu_res;
        state_d = pote_pkg::ST_MS2;
      end
      pote_pkg::ST_MS2: begin
        alu_req = '{a: pote_pkg::to_linear(sy_q[2*pote_pkg::TS_W-1 -: pote_pkg::TS_W]),
                    b: w_q, sub: 1'b1};
        ms_d    = alu_res;
        state_d = pote_pkg::ST_SM1;
      end
      pote_pkg::ST_SM1: begin
        alu_req = '{a: pote_pkg::to_linear(ta_q), b: pote_pkg::ALU_W'(corr_q),
                    sub: 1'b0};
        w_d     = alu_res;
        state_d = pote_pkg::ST_SM2;
      end
      pote_pkg::ST_SM2: begin
        alu_req = '{a: pote_pkg::to_linear(tb_q), b: w_q, sub: 1'b1};
        w_d     = alu_res;
        state_d = pote_pkg::ST_DIFF;
      end
      pote_pkg::ST_DIFF: begin
        alu_req = '{a: ms_q, b: w_q, sub: 1'b1};
        w_d     = alu_res;
        state_d = pote_pkg::ST_ABS;
      end
      pote_pkg::ST_ABS: begin
        alu_req = '{a: w_q[pote_pkg::ALU_W-1] ? '0 : w_q,
                    b: w_q[pote_pkg::ALU_W-1] ? w_q : '0,
                    sub: w_q[pote_pkg::ALU_W-1]};
        half_d  = alu_res[pote_pkg::ACC_W:1];
        flag_d  = w_q[pote_pkg::ALU_W-1] || (w_q == '0 && ms_q[pote_pkg::ALU_W-1]);
        state_d = pote_pkg::ST_MIX;
      end
      pote_pkg::ST_MIX: begin
        prod_d  = '0;
        step_d  = '0;
        state_d = pote_pkg::ST_MIXW;
      end
      pote_pkg::ST_MIXW: begin
        if (step_q == pote_pkg::MIX_STEPS) begin
          if (quo[pote_pkg::RCP_W-1:pote_pkg::HI_W] != '0) begin
            mag_d = {{pote_pkg::HI_W{1'b1}}, pote_pkg::LAST_STEP};
          end else begin
            mag_d = {quo[pote_pkg::HI_W-1:0], rem};
          end
          state_d = tracking ? pote_pkg::ST_G1 : pote_pkg::ST_OUT;
        end else begin
          prod_d = prod_q + pp_sh;
          step_d = step_q + 1'b1;
        end
      end
      pote_pkg::ST_G1: begin
        gsign_d = (rc == WARM) ? flag_q : sign_mem;
        if (gsign_d == flag_q) begin
          alu_req = '{a: pote_pkg::ALU_W'(acc_mem), b: pote_pkg::ALU_W'(half_q),
                      sub: 1'b0};
        end else begin
          alu_req = '{a: pote_pkg::ALU_W'(half_q), b: pote_pkg::ALU_W'(acc_mem),
                      sub: 1'b1};
        end
        w_d     = alu_res;
        state_d = pote_pkg::ST_G2;
      end
      pote_pkg::ST_G2: begin
        num_d = pote_pkg::FREQ_W'(period_q) * pote_pkg::FREQ_W'(pote_pkg::FREQ_SCALE);
        if (gsign_q == flag_q) begin
          acc_d = (w_q > pote_pkg::ALU_W'(pote_pkg::ACC_MAX)) ? pote_pkg::ACC_MAX
                                                              : w_q[pote_pkg::ACC_W-1:0];
        end else if (!w_q[pote_pkg::ALU_W-1] && w_q != '0) begin
          gsign_d = ~gsign_q;
          acc_d   = w_q[pote_pkg::ACC_W-1:0];
        end else begin
          alu_req = '{a: '0, b: w_q, sub: 1'b1};
          acc_d   = alu_res[pote_pkg::ACC_W-1:0];
        end
        state_d = pote_pkg::ST_FREQ;
      end
      pote_pkg::ST_FREQ: begin
        if (acc_q == '0) begin
          freq_d  = num_q;
          state_d = pote_pkg::ST_OUT;
        end else begin
          div_req = '{start: 1'b1, dividend: pote_pkg::DIV_W'(num_q), divisor: acc_q};
          state_d = pote_pkg::ST_FREQW;
        end
      end
      pote_pkg::ST_FREQW: begin
        if (div_rsp.done) begin
          freq_d  = div_rsp.quotient[pote_pkg::FREQ_W-1:0];
          state_d = pote_pkg::ST_OUT;
        end
      end
      pote_pkg::ST_OUT: begin
        gwr     = 1'b1;
        gwdata  = tracking ? {rc_new, acc_q, gsign_q} : {rc_new, acc_mem, sign_mem};
        state_d = pote_pkg::ST_IDLE;
      end
      default: begin
        state_d = pote_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pote_pkg::ST_CLR;
      clr_q       <= '0;
      period_q    <= pote_pkg::PER_W'(1);
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      res_valid_q <= (state_q == pote_pkg::ST_OUT);
      if (cfg_wr && paddr[2] == pote_pkg::REG_SYNC_PERIOD) begin
        period_q <= pwdata[pote_pkg::PER_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    w_q     <= w_d;
    ms_q    <= ms_d;
    flag_q  <= flag_d;
    gsign_q <= gsign_d;
    half_q  <= half_d;
    acc_q   <= acc_d;
    mag_q   <= mag_d;
    num_q   <= num_d;
    freq_q  <= freq_d;
    prod_q  <= prod_d;
    step_q  <= step_d;
    if (accept) begin
      node_q <= addr_i;
      ta_q   <= ts_first_i;
      tb_q   <= ts_second_i;
      corr_q <= correction_i;
    end
    if (state_q == pote_pkg::ST_OUT) begin
      res_mag_q   <= mag_q;
      res_sign_q  <= flag_q;
      res_gen_q   <= tracking && (acc_q != '0);
      res_gsign_q <= tracking && gsign_q;
      res_freq_q  <= tracking ? freq_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && node_ok && operation_i == pote_pkg::OP_SYNC) begin
      sync_mem[addr_i] <= {ts_first_i, ts_second_i, correction_i};
    end
    if (state_q == pote_pkg::ST_IDLE) begin
      sy_q <= sync_mem[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (gwr) begin
      guide_mem[(state_q == pote_pkg::ST_CLR) ? clr_q : node_q] <= gwdata;
    end
    if (state_q == pote_pkg::ST_IDLE) begin
      gd_q <= guide_mem[addr_i];
    end
  end

  assign result_valid_o     = res_valid_q;
  assign offset_magnitude_o = res_mag_q;
  assign offset_sign_o      = res_sign_q;
  assign guide_enable_o     = res_gen_q;
  assign guide_sign_o       = res_gsign_q;
  assign guide_frequency_o  = res_freq_q;

endmodule

// ===== rtl/core/pote_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared adder
// One wide add or subtract, reused by the sequencer's timestamp, offset and guide accumulator steps.
// ----------------------------------------------------------------------------
module pote_alu (
  input  pote_pkg::alu_req_t           req_i,
  output logic [pote_pkg::ALU_W-1:0]   res_o
);

  assign res_o = req_i.sub ? (req_i.a - req_i.b) : (req_i.a + req_i.b);

endmodule

// ===== rtl/core/pote_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pote_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pote_pkg::div_req_t req_i,
  output pote_pkg::div_rsp_t rsp_o
);

  logic [pote_pkg::DIV_W-1:0]  rem_q, rem_d;
  logic [pote_pkg::DIV_W-1:0]  quo_q, quo_d;
  logic [pote_pkg::DIV_W-1:0]  dvs_q, dvs_d;
  logic [pote_pkg::DIV_CW-1:0] cnt_q, cnt_d;
  logic                        run_q, run_d;
  logic                        done_q, done_d;
  logic [pote_pkg::DIV_W:0]    shifted;
  logic [pote_pkg::DIV_W:0]    trial;

  assign shifted = {rem_q, quo_q[pote_pkg::DIV_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0;
      quo_d = req_i.dividend;
      dvs_d = req_i.divisor;
      cnt_d = pote_pkg::DIV_CW'(pote_pkg::DIV_W);
      run_d = 1'b1;
    end else if (run_q) begin
      if (trial[pote_pkg::DIV_W]) begin
        rem_d = shifted[pote_pkg::DIV_W-1:0];
      end else begin
        rem_d = trial[pote_pkg::DIV_W-1:0];
      end
      quo_d = {quo_q[pote_pkg::DIV_W-2:0], ~trial[pote_pkg::DIV_W]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == pote_pkg::DIV_CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== rtl/core/pote_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PTP offset engine checker
// Port-level properties of the offset engine, bound to the top level.
// ----------------------------------------------------------------------------
module pote_checker #(
  parameter int unsigned NODES = 1024
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       operation_i,
  input logic [9:0] node_i,
  input logic       result_valid_o,
  input logic       pready
);

  // A delay request transfer to a node in the table keeps the engine busy.
  a_delay_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && operation_i && (32'(node_i) < NODES)) |=> busy)
    else $error("engine not busy after a delay request transfer");

  // Every result follows a busy period.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without a preceding busy period");

  // One result per item: strobes never come back to back.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

endmodule

bind ptp_offset_table_engine pote_checker #(.NODES(NODES)) u_pote_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .operation_i    (operation_i),
  .node_i         (node_i),
  .result_valid_o (result_valid_o),
  .pready         (pready)
);

// ===== bench/tb_ptp_offset_table_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PTP offset table engine testbench
// Drives Sync and delay request records through the command port, keeps a
// per-node shadow of Sync timestamps and guide tracking, and checks every
// result transfer field by field. Runs several sync periods set over APB.
// ----------------------------------------------------------------------------
module tb_ptp_offset_table_engine;

  localparam int unsigned NODE_CNT    = 1024;
  localparam int unsigned WARMUP      = 100;
  localparam logic [2:0]  ADDR_PERIOD = 3'd0;
  localparam logic [2:0]  ADDR_SPARE  = 3'd4;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned SETTLE      = 150;

  typedef struct {
    logic                        op;
    logic [9:0]                  node;
    logic [pote_pkg::TS_W-1:0]   ts_a;
    logic [pote_pkg::TS_W-1:0]   ts_b;
    logic [pote_pkg::TS_W-1:0]   corr;
  } record_t;

  typedef struct {
    logic [pote_pkg::MAG_W-1:0]  mag;
    logic                        osign;
    logic                        genable;
    logic                        gsign;
    logic [pote_pkg::FREQ_W-1:0] freq;
  } offset_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic operation_i = 1'b0;
  logic [9:0] node_i = '0;
  logic [pote_pkg::TS_W-1:0] ts_first_i = '0;
  logic [pote_pkg::TS_W-1:0] ts_second_i = '0;
  logic [pote_pkg::TS_W-1:0] correction_i = '0;
  logic result_valid_o;
  logic [pote_pkg::MAG_W-1:0] offset_magnitude_o;
  logic offset_sign_o;
  logic guide_enable_o;
  logic guide_sign_o;
  logic [pote_pkg::FREQ_W-1:0] guide_frequency_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ptp_offset_table_engine uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  record_t pending_q[$];
  offset_t offset_q[$];

  logic [pote_pkg::TS_W-1:0] t1_tab[NODE_CNT];
  logic [pote_pkg::TS_W-1:0] t2_tab[NODE_CNT];
  logic [pote_pkg::TS_W-1:0] corr_tab[NODE_CNT];
  int unsigned rounds_tab[NODE_CNT];
  longint unsigned acc_tab[NODE_CNT];
  bit asign_tab[NODE_CNT];
  bit synced_gen[NODE_CNT];
  logic [pote_pkg::PER_W-1:0] period_shadow = pote_pkg::PER_W'(1);

  bit taken = 1'b0;
  bit calm = 1'b0;
  int errors = 0;
  int delay_results = 0;
  int tracked_results = 0;
  int unsigned cycles = 0;
  logic [9:0] hot_nodes[4] = '{10'd0, 10'd1023, 10'd5, 10'd77};

  function automatic longint lin_count(logic [pote_pkg::TS_W-1:0] v);
    return longint'(v[pote_pkg::TS_W-1:7]) * 125 + longint'(v[6:0]);
  endfunction

  function automatic logic [pote_pkg::MAG_W-1:0] mixed_form(longint unsigned n);
    longint unsigned hi;
    hi = n / 125;
    if (hi > ((64'd1 << 42) - 1)) return {42'h3FF_FFFF_FFFF, 7'd124};
    return {hi[41:0], 7'(n % 125)};
  endfunction

  task automatic predict_offset(input record_t r);
    longint ms, sm, d;
    longint unsigned half, acc;
    offset_t e;
    bit flag, gs;
    if (r.op == pote_pkg::OP_SYNC) begin
      t1_tab[r.node] = r.ts_a;
      t2_tab[r.node] = r.ts_b;
      corr_tab[r.node] = r.corr;
      return;
    end
    ms = lin_count(t2_tab[r.node]) - (lin_count(t1_tab[r.node]) + longint'(corr_tab[r.node]));
    sm = lin_count(r.ts_b) - (lin_count(r.ts_a) + longint'(r.corr));
    d = ms - sm;
    flag = (d < 0 || (d == 0 && ms < 0));
    half = (d < 0 ? -d : d) >> 1;
    e.mag = mixed_form(half);
    e.osign = flag;
    e.genable = 1'b0;
    e.gsign = 1'b0;
    e.freq = '0;
    if (rounds_tab[r.node] >= WARMUP) begin
      acc = acc_tab[r.node];
      gs = (rounds_tab[r.node] == WARMUP) ? flag : asign_tab[r.node];
      if (gs == flag) begin
        acc = (acc + half > ((64'd1 << 50) - 1)) ? ((64'd1 << 50) - 1) : acc + half;
      end else if (half > acc) begin
        gs = ~gs;
        acc = half - acc;
      end else begin
        acc = acc - half;
      end
      acc_tab[r.node] = acc;
      asign_tab[r.node] = gs;
      e.genable = (acc != 0);
      e.gsign = gs;
      e.freq = pote_pkg::FREQ_W'(acc != 0 ? (longint'(period_shadow) * 125000) / acc
                                          : longint'(period_shadow) * 125000);
      tracked_results++;
    end
    if (rounds_tab[r.node] <= WARMUP) rounds_tab[r.node]++;
    offset_q.push_back(e);
  endtask

  // Acceptance and prediction.
  always @(posedge clk_i) begin
    record_t cur;
    if (start && !busy) begin
      cur.op = operation_i;
      cur.node = node_i;
      cur.ts_a = ts_first_i;
      cur.ts_b = ts_second_i;
      cur.corr = correction_i;
      predict_offset(cur);
      taken <= 1'b1;
    end
  end

  // Command driver.
  always @(negedge clk_i) begin
    record_t nxt;
    if (!start || taken) begin
      taken <= 1'b0;
      if (pending_q.size() != 0 && rst_ni && (calm || $urandom_range(0, 99) >= 37)) begin
        nxt = pending_q.pop_front();
        operation_i <= nxt.op;
        node_i <= nxt.node;
        ts_first_i <= nxt.ts_a;
        ts_second_i <= nxt.ts_b;
        correction_i <= nxt.corr;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    offset_t e;
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (result_valid_o) begin
      if (offset_q.size() == 0) begin
        $error("Unexpected result transfer");
        errors++;
      end else begin
        e = offset_q.pop_front();
        delay_results++;
        if (offset_magnitude_o !== e.mag) begin
          $error("offset_magnitude exp %h got %h", e.mag, offset_magnitude_o);
          errors++;
        end
        if (offset_sign_o !== e.osign) begin
          $error("offset_sign exp %b got %b", e.osign, offset_sign_o);
          errors++;
        end
        if (guide_enable_o !== e.genable) begin
          $error("guide_enable exp %b got %b", e.genable, guide_enable_o);
          errors++;
        end
        if (guide_sign_o !== e.gsign) begin
          $error("guide_sign exp %b got %b", e.gsign, guide_sign_o);
          errors++;
        end
        if (guide_frequency_o !== e.freq) begin
          $error("guide_frequency exp %0d got %0d", e.freq, guide_frequency_o);
          errors++;
        end
      end
    end
  end

  task automatic add_record(logic op, logic [9:0] nd, logic [pote_pkg::TS_W-1:0] a,
                            logic [pote_pkg::TS_W-1:0] b, logic [pote_pkg::TS_W-1:0] c);
    record_t r;
    r.op = op;
    r.node = nd;
    r.ts_a = a;
    r.ts_b = b;
    r.corr = c;
    if (op == pote_pkg::OP_SYNC) synced_gen[nd] = 1'b1;
    pending_q.push_back(r);
  endtask

  function automatic logic [pote_pkg::TS_W-1:0] rand_wide();
    return pote_pkg::TS_W'({$urandom, $urandom});
  endfunction

  task automatic add_random_record();
    logic [9:0] nd;
    logic op;
    logic [pote_pkg::TS_W-1:0] a, b, c;
    nd = ($urandom_range(0, 99) < 70) ? hot_nodes[$urandom_range(0, 3)]
                                      : 10'($urandom_range(0, 1023));
    op = (!synced_gen[nd] || $urandom_range(0, 99) < 35) ? pote_pkg::OP_SYNC
                                                         : pote_pkg::OP_DELAY;
    if ($urandom_range(0, 9) < 7) begin
      a = rand_wide();
      a[6:0] = 7'($urandom_range(0, 124));
      b = {a[pote_pkg::TS_W-1:7] + 41'($urandom_range(0, 50)), 7'($urandom_range(0, 124))};
      c = pote_pkg::TS_W'($urandom_range(0, 1000));
    end else begin
      a = rand_wide();
      b = rand_wide();
      c = rand_wide();
    end
    add_record(op, nd, a, b, c);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_PERIOD) period_shadow = v[pote_pkg::PER_W-1:0];
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || offset_q.size() != 0 || start || busy)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    logic [pote_pkg::PER_W-1:0] periods[4];
    periods = '{pote_pkg::PER_W'(2000), pote_pkg::PER_W'(0), pote_pkg::PER_W'(2047),
                pote_pkg::PER_W'($urandom_range(1, 2000))};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    write_reg(ADDR_PERIOD, 32'd1);
    write_reg(ADDR_SPARE, 32'hFFFF_FFFF);

    // Zero paths, equal negative paths, out-of-radix digits, full-scale fields.
    add_record(pote_pkg::OP_SYNC, 10'd0, '0, '0, '0);
    add_record(pote_pkg::OP_DELAY, 10'd0, '0, '0, '0);
    add_record(pote_pkg::OP_SYNC, 10'd1, '0, '0, pote_pkg::TS_W'(5));
    add_record(pote_pkg::OP_DELAY, 10'd1, '0, '0, pote_pkg::TS_W'(5));
    add_record(pote_pkg::OP_SYNC, 10'd2, {41'd3, 7'd127}, {41'd9, 7'd125},
               pote_pkg::TS_W'(1));
    add_record(pote_pkg::OP_DELAY, 10'd2, {41'd2, 7'd126}, {41'd4, 7'd127}, '0);
    add_record(pote_pkg::OP_SYNC, 10'd1023, '1, '1, '1);
    add_record(pote_pkg::OP_DELAY, 10'd1023, '0, '1, '0);
    add_record(pote_pkg::OP_DELAY, 10'd1023, '1, '0, '1);
    add_record(pote_pkg::OP_SYNC, 10'd3, '0, '1, '0);
    add_record(pote_pkg::OP_DELAY, 10'd3, '1, '0, '1);
    add_record(pote_pkg::OP_DELAY, 10'd3, '0, '1, '0);

    for (int ph = 0; ph < 4; ph++) begin
      calm = (ph == 2);
      for (int i = 0; i < 460; i++) add_random_record();
      drain();
      write_reg(ADDR_PERIOD, 32'(periods[ph]));
    end
    drain();

    $display("Checked %0d offset results, %0d of them with guide tracking active.",
             delay_results, tracked_results);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
